### hdl/rgb_box_downscale_to_gray_core_macros.svh
// Assertion macros for the box downscaler.
`ifndef RGB_BOX_DOWNSCALE_TO_GRAY_CORE_MACROS_SVH
`define RGB_BOX_DOWNSCALE_TO_GRAY_CORE_MACROS_SVH

// Implication in the same cycle, reset masked.
`define RBDG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, reset masked.
`define RBDG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rbdg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbdg_pkg
// Shared types, register map and helpers of the box downscaler.
// ---------------------------------------------------------------------------
package rbdg_pkg;

    // register indexes
    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_TGT_W = 3'd2;
    localparam logic [2:0] REG_TGT_H = 3'd3;
    localparam logic [2:0] REG_BPP   = 3'd4;

    localparam logic [12:0] RST_SRC_W = 13'd640;
    localparam logic [12:0] RST_SRC_H = 13'd480;
    localparam logic [10:0] RST_TGT_W = 11'd64;
    localparam logic [12:0] RST_TGT_H = 13'd48;
    localparam logic [3:0]  RST_BPP   = 4'd8;

    typedef struct packed {
        logic kick;      // restart pulse, the cycle after a register write, and held during reset
        logic busy;      // restart in progress
        logic clearing;  // sum memory clear pass owns the write port
    } t_cfg_ctl;

    // floor(s/3) for s <= 765 by reciprocal 683/2048
    function automatic logic [7:0] f_gray3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'd683;
        return p[18:11];
    endfunction

endpackage

### hdl/rbdg_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbdg_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module rbdg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rbdg_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbdg_div
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W.
// ---------------------------------------------------------------------------
module rbdg_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 34,
    parameter int QUO_W = 8,
    localparam int XW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W,
    localparam int CW = $clog2(QUO_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    logic [XW-1:0]    r_rem;
    logic [XW-1:0]    r_den;
    logic [QUO_W-1:0] r_quot;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_ge;

    assign w_ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= XW'(i_num);
            r_den  <= XW'(i_den) << (QUO_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_den;
            end
            r_quot <= QUO_W'({r_quot, w_ge});
            r_den  <= r_den >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### hdl/rbdg_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbdg_cfg
// APB register file and restart sequencer: clamps, block edges, sum clear.
// ---------------------------------------------------------------------------
module rbdg_cfg #(
    parameter int MAX_TARGET_WIDTH = 1024,
    parameter int MAX_SOURCE_DIM   = 4096,
    localparam int EW  = $clog2(MAX_SOURCE_DIM + 1),
    localparam int TW  = $clog2(MAX_TARGET_WIDTH + 1),
    localparam int AW  = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output rbdg_pkg::t_cfg_ctl   o_ctl,
    output logic [AW-1:0]        o_clr_addr,
    output logic [EW-1:0]        o_eff_w,
    output logic [EW-1:0]        o_eff_h,
    output logic [EW-1:0]        o_edge_x,
    output logic [EW-1:0]        o_edge_y,
    output logic [7:0]           o_maxval
);
    import rbdg_pkg::*;

    localparam int NW = $clog2(MAX_SOURCE_DIM + MAX_TARGET_WIDTH);
    localparam int DW = (EW > TW) ? EW : TW;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_X    = 2'd1;
    localparam logic [1:0] E_Y    = 2'd2;

    logic [12:0]   r_src_w;
    logic [12:0]   r_src_h;
    logic [10:0]   r_tgt_w;
    logic [12:0]   r_tgt_h;
    logic [3:0]    r_bpp;
    logic          r_kick;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [1:0]    r_estate;
    logic [EW-1:0] r_edge_x;
    logic [EW-1:0] r_edge_y;

    logic          w_wr;
    logic [EW-1:0] w_eff_w;
    logic [EW-1:0] w_eff_h;
    logic [TW-1:0] w_tw;
    logic [EW-1:0] w_th;
    logic [NW-1:0] w_num;
    logic [DW-1:0] w_den;
    logic          w_start;
    logic          w_done;
    logic [NW-1:0] w_quot;
    logic [3:0]    w_bits;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_W;
            r_src_h <= RST_SRC_H;
            r_tgt_w <= RST_TGT_W;
            r_tgt_h <= RST_TGT_H;
            r_bpp   <= RST_BPP;
            r_kick  <= 1'b1;
        end else begin
            r_kick <= 1'b0;
            if (w_wr) begin
                unique case (paddr[4:2])
                    REG_SRC_W: begin r_src_w <= pwdata[12:0]; r_kick <= 1'b1; end
                    REG_SRC_H: begin r_src_h <= pwdata[12:0]; r_kick <= 1'b1; end
                    REG_TGT_W: begin r_tgt_w <= pwdata[10:0]; r_kick <= 1'b1; end
                    REG_TGT_H: begin r_tgt_h <= pwdata[12:0]; r_kick <= 1'b1; end
                    REG_BPP:   begin r_bpp   <= pwdata[3:0];  r_kick <= 1'b1; end
                    default:   ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SRC_W: prdata = 32'(r_src_w);
            REG_SRC_H: prdata = 32'(r_src_h);
            REG_TGT_W: prdata = 32'(r_tgt_w);
            REG_TGT_H: prdata = 32'(r_tgt_h);
            REG_BPP:   prdata = 32'(r_bpp);
            default:   prdata = 32'd0;
        endcase
    end

    // clamp to the legal ranges
    always_comb begin
        if (r_src_w == 13'd0) begin
            w_eff_w = EW'(1);
        end else if (32'(r_src_w) > 32'(MAX_SOURCE_DIM)) begin
            w_eff_w = EW'(MAX_SOURCE_DIM);
        end else begin
            w_eff_w = EW'(r_src_w);
        end
        if (r_src_h == 13'd0) begin
            w_eff_h = EW'(1);
        end else if (32'(r_src_h) > 32'(MAX_SOURCE_DIM)) begin
            w_eff_h = EW'(MAX_SOURCE_DIM);
        end else begin
            w_eff_h = EW'(r_src_h);
        end
        if (r_tgt_w == 11'd0) begin
            w_tw = TW'(1);
        end else if (32'(r_tgt_w) > 32'(MAX_TARGET_WIDTH)) begin
            w_tw = TW'(MAX_TARGET_WIDTH);
        end else begin
            w_tw = TW'(r_tgt_w);
        end
        if (r_tgt_h == 13'd0) begin
            w_th = EW'(1);
        end else if (32'(r_tgt_h) > 32'(MAX_SOURCE_DIM)) begin
            w_th = EW'(MAX_SOURCE_DIM);
        end else begin
            w_th = EW'(r_tgt_h);
        end
    end

    // ceiling divisions share one divider: x first, then y
    always_comb begin
        if ((r_estate == E_X) && !r_kick) begin
            w_num = NW'(w_eff_h) + NW'(w_th) - NW'(1);
            w_den = DW'(w_th);
        end else begin
            w_num = NW'(w_eff_w) + NW'(w_tw) - NW'(1);
            w_den = DW'(w_tw);
        end
    end

    assign w_start = r_kick || (w_done && (r_estate == E_X));

    rbdg_div #(
        .NUM_W(NW),
        .DEN_W(DW),
        .QUO_W(NW)
    ) u_edge_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    // a new write restarts the sequence from the x edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estate <= E_IDLE;
        end else if (r_kick) begin
            r_estate <= E_X;
        end else begin
            unique case (r_estate)
                E_IDLE: r_estate <= E_IDLE;
                E_X:    if (w_done) r_estate <= E_Y;
                E_Y:    if (w_done) r_estate <= E_IDLE;
                default: r_estate <= E_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && (r_estate == E_X)) begin
            r_edge_x <= w_quot[EW-1:0];
        end
        if (w_done && (r_estate == E_Y)) begin
            r_edge_y <= w_quot[EW-1:0];
        end
    end

    // sweep the column sums back to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b0;
            r_clr_addr <= '0;
        end else if (r_kick) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (32'(r_clr_addr) == 32'(MAX_TARGET_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign w_bits = (r_bpp > 4'd8) ? 4'd8 : r_bpp;

    assign o_maxval      = 8'((9'd1 << w_bits) - 9'd1);
    assign o_ctl.kick    = r_kick;
    assign o_ctl.busy    = r_kick || r_clearing || (r_estate != E_IDLE);
    assign o_ctl.clearing = r_clearing;
    assign o_clr_addr    = r_clr_addr;
    assign o_eff_w       = w_eff_w;
    assign o_eff_h       = w_eff_h;
    assign o_edge_x      = r_edge_x;
    assign o_edge_y      = r_edge_y;

endmodule

### hdl/rgb_box_downscale_to_gray_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_box_downscale_to_gray_core
// Box-filter downscale of an RGB raster stream to gray block averages.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                      payload
//  pixel    in         i_in_valid / o_in_stall        i_red, i_green, i_blue
//  block    out        o_out_valid / i_out_stall      o_gray_value, o_out_row,
//                                                     o_out_col, o_last_of_image
//  config   in         APB psel/penable/pwrite        paddr, pwdata, prdata
//
// A pixel that closes no block is handled in two steps: accept with sum read, write back.
// A block's bottom-right pixel then passes the multiply stage and the 8-step
// quotient divider before its result is put into the output register.
// After reset or a write to any of the five registers the sum memory is
// cleared one entry a cycle, with pixel requests stalled.
// A held result does not block the next pixel; only a second result waits.
// ---------------------------------------------------------------------------
module rgb_box_downscale_to_gray_core #(
    parameter int MAX_TARGET_WIDTH = 1024,
    parameter int MAX_SOURCE_DIM   = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_gray_value,
    output logic [11:0] o_out_row,
    output logic [9:0]  o_out_col,
    output logic        o_last_of_image,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbdg_pkg::*;

    localparam int EW  = $clog2(MAX_SOURCE_DIM + 1);
    localparam int PW  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
    localparam int CW  = $clog2(MAX_TARGET_WIDTH + 1);
    localparam int AW  = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
    localparam int NPW = 2 * (PW + 1);
    localparam int DNW = NPW + 8;

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_RD   = 3'd1;
    localparam logic [2:0] P_MUL  = 3'd2;
    localparam logic [2:0] P_DIV  = 3'd3;
    localparam logic [2:0] P_PUT  = 3'd4;

    t_cfg_ctl      w_ctl;
    logic [AW-1:0] w_clr_addr;
    logic [EW-1:0] w_eff_w;
    logic [EW-1:0] w_eff_h;
    logic [EW-1:0] w_edge_x;
    logic [EW-1:0] w_edge_y;
    logic [7:0]    w_maxval;

    logic [2:0]    r_state;
    logic [2:0]    n_state;

    // position counters
    logic [PW-1:0] r_px;
    logic [PW-1:0] r_py;
    logic [PW-1:0] r_ibx;
    logic [PW-1:0] r_iby;
    logic [CW-1:0] r_bc;
    logic [PW-1:0] r_br;

    // item in flight
    logic [7:0]    r_gray;
    logic [AW-1:0] r_col;
    logic          r_emit;
    logic          r_last;
    logic [PW-1:0] r_it_bx;
    logic [PW-1:0] r_it_by;
    logic [PW-1:0] r_it_row;
    logic [CW-1:0] r_it_col;
    logic [39:0]   r_prod;
    logic [NPW-1:0] r_npix;

    // output register
    logic          r_ovalid;
    logic [7:0]    r_ogray;
    logic [11:0]   r_orow;
    logic [9:0]    r_ocol;
    logic          r_olast;

    logic          w_accept;
    logic          w_end_x;
    logic          w_end_y;
    logic          w_row_end;
    logic          w_img_end;
    logic [AW-1:0] w_col;
    logic [31:0]   w_rdata;
    logic [31:0]   w_acc;
    logic          w_dp_we;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [39:0]   w_prod;
    logic [NPW-1:0] w_npix;
    logic          w_q_start;
    logic          w_q_done;
    logic [7:0]    w_quot;
    logic          w_put;

    rbdg_cfg #(
        .MAX_TARGET_WIDTH(MAX_TARGET_WIDTH),
        .MAX_SOURCE_DIM  (MAX_SOURCE_DIM)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_ctl     (w_ctl),
        .o_clr_addr(w_clr_addr),
        .o_eff_w   (w_eff_w),
        .o_eff_h   (w_eff_h),
        .o_edge_x  (w_edge_x),
        .o_edge_y  (w_edge_y),
        .o_maxval  (w_maxval)
    );

    assign o_in_stall = (r_state != P_IDLE) || w_ctl.busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_end_x   = ((EW + 1)'(r_ibx) + 1'b1 == (EW + 1)'(w_edge_x)) ||
                       ((EW + 1)'(r_px) + 1'b1 >= (EW + 1)'(w_eff_w));
    assign w_end_y   = ((EW + 1)'(r_iby) + 1'b1 == (EW + 1)'(w_edge_y)) ||
                       ((EW + 1)'(r_py) + 1'b1 >= (EW + 1)'(w_eff_h));
    assign w_row_end = ((EW + 1)'(r_px) + 1'b1 >= (EW + 1)'(w_eff_w));
    assign w_img_end = ((EW + 1)'(r_py) + 1'b1 >= (EW + 1)'(w_eff_h));
    assign w_col     = (32'(r_bc) >= 32'(MAX_TARGET_WIDTH)) ?
                       AW'(MAX_TARGET_WIDTH - 1) : r_bc[AW-1:0];

    // advance the raster position on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_ctl.kick) begin
            r_px  <= '0;
            r_py  <= '0;
            r_ibx <= '0;
            r_iby <= '0;
            r_bc  <= '0;
            r_br  <= '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                r_px  <= '0;
                r_bc  <= '0;
                r_ibx <= '0;
                if (w_img_end) begin
                    r_py  <= '0;
                    r_br  <= '0;
                    r_iby <= '0;
                end else begin
                    r_py <= r_py + 1'b1;
                    if (w_end_y) begin
                        r_iby <= '0;
                        r_br  <= r_br + 1'b1;
                    end else begin
                        r_iby <= r_iby + 1'b1;
                    end
                end
            end else begin
                r_px <= r_px + 1'b1;
                if (w_end_x) begin
                    r_ibx <= '0;
                    r_bc  <= r_bc + 1'b1;
                end else begin
                    r_ibx <= r_ibx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gray   <= f_gray3(10'(i_red) + 10'(i_green) + 10'(i_blue));
            r_col    <= w_col;
            r_emit   <= w_end_x && w_end_y;
            r_last   <= w_row_end && w_img_end;
            r_it_bx  <= r_ibx;
            r_it_by  <= r_iby;
            r_it_row <= r_br;
            r_it_col <= r_bc;
        end
    end

    rbdg_ram #(
        .WIDTH(32),
        .DEPTH(MAX_TARGET_WIDTH)
    ) u_sums (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_accept),
        .i_raddr(w_col),
        .o_rdata(w_rdata)
    );

    // read-modify-write: one item at a time, so no forwarding is needed
    assign w_acc   = w_rdata + 32'(r_gray);
    assign w_dp_we = (r_state == P_RD);
    assign w_we    = w_ctl.clearing || w_dp_we;
    assign w_waddr = w_ctl.clearing ? w_clr_addr : r_col;
    assign w_wdata = (w_ctl.clearing || r_emit) ? 32'd0 : w_acc;

    assign w_prod = 40'(w_acc) * 40'(w_maxval);
    assign w_npix = NPW'((NPW'(r_it_bx) + 1'b1) * (NPW'(r_it_by) + 1'b1));

    always_ff @(posedge i_clk) begin
        if (w_dp_we && r_emit) begin
            r_prod <= w_prod;
            r_npix <= w_npix;
        end
    end

    assign w_q_start = (r_state == P_MUL);

    rbdg_div #(
        .NUM_W(40),
        .DEN_W(DNW),
        .QUO_W(8)
    ) u_quant_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_q_start),
        .i_num  (r_prod),
        .i_den  ({r_npix, 8'd0}),
        .o_done (w_q_done),
        .o_quot (w_quot)
    );

    assign w_put = (r_state == P_PUT) && (!r_ovalid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            P_IDLE: if (w_accept) n_state = P_RD;
            P_RD:   n_state = r_emit ? P_MUL : P_IDLE;
            P_MUL:  n_state = P_DIV;
            P_DIV:  if (w_q_done) n_state = P_PUT;
            P_PUT:  if (w_put) n_state = P_IDLE;
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_put) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_ogray <= w_quot;
            r_orow  <= 12'(r_it_row);
            r_ocol  <= 10'(r_it_col);
            r_olast <= r_last;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_gray_value    = r_ogray;
    assign o_out_row       = r_orow;
    assign o_out_col       = r_ocol;
    assign o_last_of_image = r_olast;

`include "rgb_box_downscale_to_gray_core_macros.svh"

    `RBDG_ASSERT_NEXT(a_accept_reads, w_accept, r_state == P_RD, "accept did not start a read")
    `RBDG_ASSERT_NOW(a_no_clear_clash, w_dp_we, !w_ctl.clearing, "update during clear pass")
    `RBDG_ASSERT_NOW(a_done_in_div, w_q_done, r_state == P_DIV, "divider done outside wait")
    `RBDG_ASSERT_NOW(a_gray_range, o_out_valid, o_gray_value <= w_maxval, "gray above maxval")

endmodule
